// File: rtl/hand_pkg.sv
// hand_pkg: shared types and codes of the hello/ack neighbor discovery block
// no dependencies; used by every module under rtl/

package hand_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_ROUND   = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [1:0] CMD_RX      = 2'd3;

    // packet kinds
    localparam logic [7:0] KIND_HELLO = 8'd1;
    localparam logic [7:0] KIND_ACK   = 8'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_PORT_COUNT     = 2'd1;
    localparam logic [1:0] CFG_HELLO_SEQUENCE = 2'd2;

    localparam logic [4:0] CNT_MAX = 5'd31;

    typedef enum logic [2:0] {
        OP_ROUND,
        OP_TICK,
        OP_TIMEOUT,
        OP_RX_HELLO,
        OP_RX_ACK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] source;
        logic [15:0] seq_no;
        logic [3:0]  port;
    } op_item_t;

    typedef struct packed {
        logic [15:0] own_address;
        logic [4:0]  port_count;
        logic [15:0] hello_sequence;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [15:0] source;
        logic [15:0] destination;
        logic [15:0] seq_no;
        logic [3:0]  port;
        logic        seen;
        logic        last;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

endpackage

// File: rtl/hand_front.sv
// hand_front: accepts input beats, classifies them into queue operations
// depends on hand_pkg; drops received packets of unknown kind

module hand_front import hand_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // command
    input  logic [47:0] s_tdata,   // rx_kind, rx_source, rx_sequence, rx_port
    input  logic        q_full,
    output logic        q_push,
    output op_item_t    q_item
);

    logic [7:0] rx_kind;
    logic       keep;

    assign rx_kind = s_tdata[7:0];

    always_comb begin
        keep          = 1'b1;
        q_item.op     = OP_ROUND;
        q_item.source = s_tdata[23:8];
        q_item.seq_no = s_tdata[39:24];
        q_item.port   = s_tdata[43:40];
        unique case (s_tuser)
            CMD_ROUND:   q_item.op = OP_ROUND;
            CMD_TICK:    q_item.op = OP_TICK;
            CMD_TIMEOUT: q_item.op = OP_TIMEOUT;
            CMD_RX: begin
                if (rx_kind == KIND_HELLO) begin
                    q_item.op = OP_RX_HELLO;
                end else if (rx_kind == KIND_ACK) begin
                    q_item.op = OP_RX_ACK;
                end else begin
                    keep = 1'b0;
                end
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && keep;

endmodule

// File: rtl/hand_fifo.sv
// hand_fifo: two-entry queue of classified operations between front and back
// depends on hand_pkg

module hand_fifo import hand_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  op_item_t push_item,
    output logic     full,
    output logic     q_valid,
    output op_item_t q_item,
    input  logic     pop
);

    op_item_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !q_valid))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

// File: rtl/hand_back.sv
// hand_back: executes queued operations, holds port counter and pending-ack bits,
// scans pending ports on timeout and drives the result register; depends on hand_pkg

module hand_back import hand_pkg::*; #(
    parameter int MAX_PORTS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     q_valid,
    input  op_item_t q_item,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_result
);

    // ports at or above 16 can never be marked, so only this many bits are kept
    localparam int         PEND_DEPTH = (MAX_PORTS < 16) ? MAX_PORTS : 16;
    localparam logic [4:0] PEND_LIM   = 5'(PEND_DEPTH);

    back_state_t           state_reg, state_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [PEND_DEPTH-1:0] pend_reg, pend_next;
    logic [PEND_DEPTH-1:0] scan_reg, scan_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic                  out_free;
    logic                  out_load;
    logic [PEND_DEPTH-1:0] limit_mask;
    logic [PEND_DEPTH-1:0] scan_low;
    logic [PEND_DEPTH-1:0] scan_rest;
    logic [3:0]            scan_port;
    logic [4:0]            cnt_inc;
    logic [PEND_DEPTH-1:0] load_onehot;

    assign out_free = !out_valid_reg || m_ready;
    assign cnt_inc  = (cnt_reg < CNT_MAX) ? cnt_reg + 5'd1 : cnt_reg;

    // lowest pending port of the scan set
    assign scan_low  = scan_reg & (~scan_reg + 1'b1);
    assign scan_rest = scan_reg & ~scan_low;

    always_comb begin
        scan_port = 4'd0;
        for (int j = 0; j < PEND_DEPTH; j++) begin
            limit_mask[j] = (5'(j) < cfg.port_count);
            if (scan_low[j]) scan_port = 4'(j);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        out_load       = 1'b0;
        q_pop          = 1'b0;

        out_next.kind        = KIND_HELLO;
        out_next.source      = cfg.own_address;
        out_next.destination = 16'd0;
        out_next.seq_no      = cfg.hello_sequence;
        out_next.port        = 4'd0;
        out_next.seen        = 1'b0;
        out_next.last        = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        OP_ROUND: begin
                            cnt_next = 5'd0;
                            out_load = 1'b1;
                        end
                        OP_TICK: begin
                            cnt_next = cnt_inc;
                            if (cnt_inc < cfg.port_count && cnt_inc < PEND_LIM) begin
                                out_load      = 1'b1;
                                out_next.port = cnt_inc[3:0];
                            end
                        end
                        OP_TIMEOUT: begin
                            if ((pend_reg & limit_mask) != '0) begin
                                scan_next  = pend_reg & limit_mask;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_RX_HELLO: begin
                            out_load             = 1'b1;
                            out_next.kind        = KIND_ACK;
                            out_next.destination = q_item.source;
                            out_next.seq_no      = q_item.seq_no;
                            out_next.port        = q_item.port;
                            out_next.seen        = 1'b1;
                        end
                        OP_RX_ACK: begin
                            for (int j = 0; j < PEND_DEPTH; j++) begin
                                if (q_item.port == 4'(j)) pend_next[j] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_next.port = scan_port;
                    out_next.last = (scan_rest == '0);
                    scan_next     = scan_rest;
                    if (scan_rest == '0) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // every hello sent marks its port pending
        load_onehot = '0;
        for (int j = 0; j < PEND_DEPTH; j++) begin
            if (out_next.port == 4'(j)) load_onehot[j] = 1'b1;
        end
        if (out_load && out_next.kind == KIND_HELLO) pend_next = pend_next | load_onehot;

        if (out_load) out_valid_next = 1'b1;
        else out_next = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            pend_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

`ifndef ASSERT_OFF
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_reg != '0)
        else $error("scan running with empty port set");
    a_hello_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_next.kind == KIND_HELLO |-> (pend_next & load_onehot) != '0)
        else $error("hello sent without marking its port pending");
    a_hello_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.kind == KIND_HELLO |->
            !out_reg.seen && out_reg.destination == 16'd0)
        else $error("hello result carries ack fields");
    a_no_pop_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !q_pop)
        else $error("queue popped during timeout scan");
`endif

endmodule

// File: rtl/hello_ack_neighbor_discovery_top.sv
// hello_ack_neighbor_discovery_top: top level, configuration registers and wiring
// depends on hand_pkg, hand_front, hand_fifo, hand_back
//
// Usage:
//   s_ channel: one beat per event; s_tuser is the command (hello round tick,
//   port tick, ack timeout tick, received packet), s_tdata the packet header.
//   m_ channel: one beat per packet to send; m_tlast marks the last beat that
//   one input beat causes, m_tuser flags an ack that answers a neighbor hello.
//   cfg_we/cfg_addr/cfg_wdata write own_address (0), port_count (1) and
//   hello_sequence (2); write only while the block is idle.
// Timing:
//   a beat enters a two-entry queue; the executor takes one operation per cycle while
//   the result register is free; a hello or ack is registered there and drives m_.
//   An ack timeout tick with pending ports scans them: one hello per port, one per
//   cycle unless m_ stalls, up to 16 beats; no new operation is taken during the scan.
// Reset: aresetn (synchronous, active low) clears the queue, port counter,
//   pending-ack bits, output valid flag and the configuration registers.
// Stall: when m_tready is low the result register holds; the executor waits and
//   s_tready drops once the queue is full.

module hello_ack_neighbor_discovery_top import hand_pkg::*; #(
    parameter int MAX_PORTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // command
    input  logic [47:0] s_tdata,   // rx_kind, rx_source, rx_sequence, rx_port, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // tx_kind, tx_source, tx_destination, tx_sequence,
                                   // tx_port, zero pad
    output logic        m_tuser,   // neighbor_seen
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    cfg_t     cfg_reg, cfg_next;
    logic     q_full;
    logic     q_push;
    op_item_t push_item;
    logic     q_valid;
    op_item_t q_item;
    logic     q_pop;
    result_t  result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_OWN_ADDRESS:    cfg_next.own_address    = cfg_wdata;
                CFG_PORT_COUNT:     cfg_next.port_count     = cfg_wdata[4:0];
                CFG_HELLO_SEQUENCE: cfg_next.hello_sequence = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hand_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    hand_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    hand_back #(
        .MAX_PORTS (MAX_PORTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {4'd0, result.port, result.seq_no, result.destination,
                      result.source, result.kind};
    assign m_tuser = result.seen;
    assign m_tlast = result.last;

endmodule
